/* rtl/core/spp_pkg.sv */
// Shared types and constants for the string to unsigned parser.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package spp_pkg;

   localparam int OffsetBits  = 16;
   localparam int OffsetWidth = 16;
   localparam int ValueWidth  = 64;
   localparam int CharWidth   = 8;
   localparam int BaseWidth   = 6;

   localparam logic [CharWidth-1:0] CharNul    = 8'h00;
   localparam logic [CharWidth-1:0] CharSpace  = 8'h20;
   localparam logic [CharWidth-1:0] CharZero   = 8'h30;
   localparam logic [CharWidth-1:0] CharNine   = 8'h39;
   localparam logic [CharWidth-1:0] CharUpperA = 8'h41;
   localparam logic [CharWidth-1:0] CharLowerA = 8'h61;
   localparam logic [CharWidth-1:0] CharUpperX = 8'h58;
   localparam logic [CharWidth-1:0] CharLowerX = 8'h78;
   localparam logic [CharWidth-1:0] CaseShift  = 8'h20;
   localparam logic [CharWidth-1:0] LetterBase = 8'd10;

   localparam logic [BaseWidth-1:0] BaseDetect = 6'd0;
   localparam logic [BaseWidth-1:0] RadixOct   = 6'd8;
   localparam logic [BaseWidth-1:0] RadixDec   = 6'd10;
   localparam logic [BaseWidth-1:0] RadixHex   = 6'd16;

   typedef enum logic [1:0] {
      PH_SKIP,
      PH_PREFIX,
      PH_DIGITS,
      PH_IGNORE
   } phase_type;

   typedef struct packed {
      logic                 ok;
      logic [CharWidth-1:0] value;
   } digit_type;

   typedef struct packed {
      logic [ValueWidth-1:0]  value;
      logic [OffsetWidth-1:0] offset;
   } result_type;

endpackage

/* rtl/core/spp_digit_decode.sv */
// Digit decoder: maps one character to its digit value and checks it against the radix.
// Depends on spp_pkg.
`timescale 1ns / 1ps

module spp_digit_decode (
   input  logic [spp_pkg::CharWidth-1:0] char_code,
   input  logic [spp_pkg::BaseWidth-1:0] radix,
   output spp_pkg::digit_type            digit
);
   import spp_pkg::*;

   logic [CharWidth-1:0] upper;
   logic [CharWidth-1:0] value;
   logic                 is_digit;

   always_comb begin
      upper    = char_code;
      value    = '0;
      is_digit = 1'b0;
      if (char_code >= CharLowerA) begin
         upper = char_code - CaseShift;
      end
      if (upper >= CharUpperA) begin
         value    = upper - CharUpperA + LetterBase;
         is_digit = 1'b1;
      end else if (upper >= CharZero && upper <= CharNine) begin
         value    = upper - CharZero;
         is_digit = 1'b1;
      end
      digit.value = value;
      digit.ok    = is_digit && (value < {{(CharWidth-BaseWidth){1'b0}}, radix});
   end

endmodule

/* rtl/core/spp_parse_core.sv */
// Parse state machine and multiply-add accumulator, one character per step.
// Depends on spp_pkg and spp_digit_decode.
`timescale 1ns / 1ps

module spp_parse_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic [spp_pkg::CharWidth-1:0] char_code,
   input  logic [spp_pkg::BaseWidth-1:0] number_base,
   output spp_pkg::result_type           result
);
   import spp_pkg::*;

   phase_type                        phase_ff, phase_in;
   logic [ValueWidth-1:0]            acc_ff, acc_in;
   logic [BaseWidth-1:0]             radix_ff, radix_in;
   logic [OffsetBits-1:0]            pos_ff, pos_in;
   logic [OffsetBits-1:0]            stop_ff, stop_in;

   logic [BaseWidth-1:0]             radix_sel;
   digit_type                        digit;
   logic [ValueWidth+BaseWidth-1:0]  prod;
   logic [ValueWidth-1:0]            acc_next;
   logic                             is_nul;
   logic                             is_blank;

   assign is_nul   = (char_code == CharNul);
   assign is_blank = (char_code <= CharSpace);

   always_comb begin
      radix_sel = radix_ff;
      if (phase_ff == PH_SKIP) begin
         if (number_base == BaseDetect) begin
            radix_sel = (char_code == CharZero) ? RadixOct : RadixDec;
         end else if (number_base == RadixHex && char_code == CharZero) begin
            radix_sel = RadixHex;
         end else begin
            radix_sel = number_base;
         end
      end
   end

   spp_digit_decode u_digit (
      .char_code (char_code),
      .radix     (radix_sel),
      .digit     (digit)
   );

   assign prod     = {{BaseWidth{1'b0}}, acc_ff} * {{ValueWidth{1'b0}}, radix_sel};
   assign acc_next = prod[ValueWidth-1:0] + {{(ValueWidth-CharWidth){1'b0}}, digit.value};

   always_comb begin
      phase_in = phase_ff;
      acc_in   = acc_ff;
      radix_in = radix_ff;
      pos_in   = pos_ff;
      stop_in  = stop_ff;
      if (step) begin
         if (is_nul) begin
            phase_in = PH_SKIP;
            acc_in   = '0;
            radix_in = '0;
            pos_in   = '0;
            stop_in  = '0;
         end else begin
            if (pos_ff != {OffsetBits{1'b1}}) begin
               pos_in = pos_ff + OffsetBits'(1);
            end
            case (phase_ff)
               PH_SKIP: begin
                  if (!is_blank) begin
                     radix_in = radix_sel;
                     if ((number_base == BaseDetect || number_base == RadixHex)
                         && char_code == CharZero) begin
                        phase_in = PH_PREFIX;
                     end else if (digit.ok) begin
                        acc_in   = acc_next;
                        phase_in = PH_DIGITS;
                     end else begin
                        stop_in  = pos_ff;
                        phase_in = PH_IGNORE;
                     end
                  end
               end
               PH_PREFIX: begin
                  if (char_code == CharLowerX || char_code == CharUpperX) begin
                     radix_in = RadixHex;
                     acc_in   = '0;
                     phase_in = PH_DIGITS;
                  end else if (digit.ok) begin
                     acc_in   = acc_next;
                     phase_in = PH_DIGITS;
                  end else begin
                     stop_in  = pos_ff;
                     phase_in = PH_IGNORE;
                  end
               end
               PH_DIGITS: begin
                  if (digit.ok) begin
                     acc_in = acc_next;
                  end else begin
                     stop_in  = pos_ff;
                     phase_in = PH_IGNORE;
                  end
               end
               default: begin
                  phase_in = phase_ff;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SKIP;
         acc_ff   <= '0;
         radix_ff <= '0;
         pos_ff   <= '0;
         stop_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         radix_ff <= radix_in;
         pos_ff   <= pos_in;
         stop_ff  <= stop_in;
      end
   end

   always_comb begin
      result.value  = (phase_ff == PH_SKIP) ? '0 : acc_ff;
      result.offset = OffsetWidth'((phase_ff == PH_IGNORE) ? stop_ff : pos_ff);
   end

endmodule

/* rtl/core/string_to_unsigned_parser.sv */
// Top level of the string to unsigned parser: input register, parse core, result register.
// Depends on spp_pkg and spp_parse_core.
//
//   port group   direction   beat carries
//   req_*        in          one string byte (req_char_code)
//   rsp_*        out         parsed_value and end_offset, one beat per NUL byte
//   csr_*        in          number_base, always ready
//
// One byte per cycle while no NUL byte waits on a stalled result; a NUL beat
// is loaded into the result register at the edge where it leaves the input register.
// The multiply-add in the parse core is combinational and feeds its
// accumulator register. Reset clears all parse state and number_base.
// A stalled result holds back a NUL byte and the bytes behind it; other
// bytes keep flowing while rsp_ready is low until a NUL byte is waiting.
`timescale 1ns / 1ps

module string_to_unsigned_parser (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [spp_pkg::CharWidth-1:0]   req_char_code,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [spp_pkg::ValueWidth-1:0]  rsp_parsed_value,
   output logic [spp_pkg::OffsetWidth-1:0] rsp_end_offset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [spp_pkg::BaseWidth-1:0]   csr_number_base
);
   import spp_pkg::*;

   logic                   in_valid_ff, in_valid_in;
   logic [CharWidth-1:0]   in_char_ff, in_char_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   result_type             rsp_data_ff, rsp_data_in;
   logic [BaseWidth-1:0]   base_ff, base_in;

   result_type             result;
   logic                   is_nul;
   logic                   out_free;
   logic                   advance;

   assign is_nul   = (in_char_ff == CharNul);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign advance  = in_valid_ff && (!is_nul || out_free);

   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;

   spp_parse_core u_core (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .char_code   (in_char_ff),
      .number_base (base_ff),
      .result      (result)
   );

   always_comb begin
      in_valid_in  = req_ready ? req_valid : in_valid_ff;
      in_char_in   = (req_valid && req_ready) ? req_char_code : in_char_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (advance && is_nul) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end
      base_in = csr_valid ? csr_number_base : base_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         base_ff      <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         base_ff      <= base_in;
      end
   end

   always_ff @(posedge clock) begin
      in_char_ff  <= in_char_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_parsed_value = rsp_data_ff.value;
   assign rsp_end_offset   = rsp_data_ff.offset;

endmodule

/* rtl/core/spp_checker.sv */
// Port-level checks for the string to unsigned parser, bound to the top level.
// Depends on spp_pkg and string_to_unsigned_parser.
`timescale 1ns / 1ps

module spp_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic [spp_pkg::CharWidth-1:0]   req_char_code,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [spp_pkg::ValueWidth-1:0]  rsp_parsed_value,
   input logic [spp_pkg::OffsetWidth-1:0] rsp_end_offset,
   input logic                            csr_valid,
   input logic                            csr_ready,
   input logic [spp_pkg::BaseWidth-1:0]   csr_number_base
);
   import spp_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_parsed_value)
         && $stable(rsp_end_offset))
      else $error("result beat changed while stalled");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("result pending or input blocked after reset");

   a_idle_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready && csr_ready)
      else $error("input blocked with no result pending");

   a_zero_offset: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_offset == '0 |-> rsp_parsed_value == '0)
      else $error("nonzero value with nothing consumed");

endmodule

bind string_to_unsigned_parser spp_checker u_spp_checker (.*);
